FILE: rtl/pixel_frame_bitplane_decoder_macros.svh
// Assertion shorthands shared by the decoder modules.
`ifndef PIXEL_FRAME_BITPLANE_DECODER_MACROS_SVH
`define PIXEL_FRAME_BITPLANE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PFBD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PFBD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pfbd_pkg.sv
`timescale 1ns / 1ps

package pfbd_pkg;

   localparam int PIXELS        = 16;
   localparam int PIX_W         = 16;
   localparam int PIX_IDX_W     = 4;
   localparam int FRAME_BYTES   = 40;
   localparam int PLANE_BYTES   = 32;
   localparam int HEADER_BYTES  = 8;
   localparam int FOOTER_BYTES  = 16;
   localparam int FOOTER_MATCH  = 3;
   localparam int FRAME_NUM_W   = 27;
   localparam int EVENT_NUM_W   = 32;
   localparam int LENGTH_W      = 32;

   localparam logic [15:0] TRAILER_MID = 16'hFEFE;
   localparam logic [15:0] TRAILER_END = 16'hAEAE;

   localparam logic [63:0] PIXEL_MAP_RESET = 64'hFEDC_BA98_7654_3210;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_MAP      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_PATTERN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FOOTER_PATTERN = 2'd2;

   // Frame queue between the parser and the result serializer.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [PIXELS-1:0][PIX_W-1:0] pixel_vec_type;

   typedef struct packed {
      pixel_vec_type            pixels;
      logic [FRAME_NUM_W-1:0]   frame_number;
      logic [EVENT_NUM_W-1:0]   event_number;
      logic                     trailer_ok;
      logic                     header_ok;
      logic                     final_frame;
   } frame_rec_type;

   typedef struct packed {
      logic          valid;
      frame_rec_type rec;
   } queue_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

FILE: rtl/pfbd_if.sv
`timescale 1ns / 1ps

// Byte request channel.
interface pfbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// Pixel result channel.
interface pfbd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [pfbd_pkg::PIX_IDX_W-1:0]       pixel_index;
   logic [pfbd_pkg::PIX_W-1:0]           pixel_value;
   logic [pfbd_pkg::FRAME_NUM_W-1:0]     frame_number;
   logic [pfbd_pkg::EVENT_NUM_W-1:0]     event_number;
   logic                                 trailer_ok;
   logic                                 header_ok;
   logic                                 final_frame;
   logic                                 last;

   modport source (output valid, output pixel_index, output pixel_value,
                   output frame_number, output event_number, output trailer_ok,
                   output header_ok, output final_frame, output last,
                   input ready);
   modport sink   (input valid, input pixel_index, input pixel_value,
                   input frame_number, input event_number, input trailer_ok,
                   input header_ok, input final_frame, input last,
                   output ready);
endinterface

FILE: rtl/pfbd_front.sv
`timescale 1ns / 1ps
`include "pixel_frame_bitplane_decoder_macros.svh"

// Stream parser: header, payload frames with bit-plane accumulation,
// footer lookahead and footer skip. Hands finished frames to the queue.
module pfbd_front (
   input  logic                                clock,
   input  logic                                reset,
   pfbd_req_if.sink                            req_bus,
   input  logic                                csr_we,
   input  logic [pfbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                         csr_wdata,
   input  pfbd_pkg::queue_stat_type            stat,
   output pfbd_pkg::queue_push_type            push
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_LOOK,
      PH_SKIP
   } phase_type;

   phase_type                                  phase_ff, phase_in;
   logic [2:0]                                 hpos_ff, hpos_in;
   logic [23:0]                                len_ff, len_in;
   logic [pfbd_pkg::LENGTH_W-1:0]              rem_ff, rem_in;
   logic [5:0]                                 fbyte_ff, fbyte_in;
   logic [pfbd_pkg::FRAME_NUM_W-1:0]           findex_ff, findex_in;
   logic [pfbd_pkg::EVENT_NUM_W-1:0]           ecount_ff, ecount_in;
   pfbd_pkg::pixel_vec_type                    acc_ff, acc_in;
   logic                                       hmatch_ff, hmatch_in;
   logic [7:0]                                 thigh_ff, thigh_in;
   logic [15:0]                                look_ff, look_in;
   logic                                       fin_ff, fin_in;

   logic [pfbd_pkg::PIXELS-1:0][3:0]           cfg_map_ff;
   logic [23:0]                                cfg_header_ff;
   logic [23:0]                                cfg_footer_ff;

   logic                                       req_fire;
   logic                                       frame_end_now;
   logic                                       frame_active;
   logic                                       hdr_eq;
   logic [pfbd_pkg::LENGTH_W-1:0]              full_len;
   logic [23:0]                                three;
   logic [3:0]                                 plane;
   logic [3:0]                                 bit_cnt [pfbd_pkg::PIXELS];
   pfbd_pkg::pixel_vec_type                    acc_sum;
   logic [15:0]                                trailer_want;

   assign frame_end_now = (phase_ff == PH_PAYLOAD)
                        && (fbyte_ff == 6'(pfbd_pkg::FRAME_BYTES - 1));
   // Only a frame-closing byte needs a free queue slot.
   assign req_bus.ready = !(stat.full && frame_end_now);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // A frame starts only when a whole frame remains in the payload.
   assign frame_active = (fbyte_ff != 6'd0)
                       || (rem_ff >= pfbd_pkg::LENGTH_W'(pfbd_pkg::FRAME_BYTES));

   assign hdr_eq   = (req_bus.data_byte == cfg_header_ff[{hpos_ff[1:0], 3'b000} +: 8]);
   assign full_len = {req_bus.data_byte, len_ff};
   assign three    = {req_bus.data_byte, look_ff};
   assign plane    = ~fbyte_ff[4:1];

   // Each slot bit of the byte adds its plane weight to the mapped pixel.
   always_comb begin
      for (int p = 0; p < pfbd_pkg::PIXELS; p++) begin
         bit_cnt[p] = 4'd0;
         for (int d = 0; d < 8; d++) begin
            if (req_bus.data_byte[d]
                && (cfg_map_ff[{fbyte_ff[0], 3'(d)}] == 4'(p))) begin
               bit_cnt[p] = bit_cnt[p] + 4'd1;
            end
         end
         acc_sum[p] = acc_ff[p] + (16'(bit_cnt[p]) << plane);
      end
   end

   assign trailer_want = fin_ff ? pfbd_pkg::TRAILER_END : pfbd_pkg::TRAILER_MID;

   always_comb begin
      push.valid            = req_fire && frame_end_now;
      push.rec.pixels       = acc_ff;
      push.rec.frame_number = findex_ff;
      push.rec.event_number = ecount_ff;
      push.rec.trailer_ok   = ({thigh_ff, req_bus.data_byte} == trailer_want);
      push.rec.header_ok    = hmatch_ff;
      push.rec.final_frame  = fin_ff;
   end

   always_comb begin
      phase_in  = phase_ff;
      hpos_in   = hpos_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      fbyte_in  = fbyte_ff;
      findex_in = findex_ff;
      ecount_in = ecount_ff;
      acc_in    = acc_ff;
      hmatch_in = hmatch_ff;
      thigh_in  = thigh_ff;
      look_in   = look_ff;
      fin_in    = fin_ff;
      if (req_fire) begin
         case (phase_ff)
            PH_HEADER: begin
               if (hpos_ff < 3'd3) begin
                  hmatch_in = (hpos_ff == 3'd0) ? hdr_eq : (hmatch_ff & hdr_eq);
               end
               case (hpos_ff)
                  3'd4:    len_in[7:0]   = req_bus.data_byte;
                  3'd5:    len_in[15:8]  = req_bus.data_byte;
                  3'd6:    len_in[23:16] = req_bus.data_byte;
                  default: ;
               endcase
               if (hpos_ff == 3'(pfbd_pkg::HEADER_BYTES - 1)) begin
                  hpos_in   = 3'd0;
                  rem_in    = full_len;
                  fbyte_in  = 6'd0;
                  findex_in = '0;
                  acc_in    = '0;
                  if (full_len == '0) begin
                     ecount_in = ecount_ff + 1'b1;
                     phase_in  = PH_LOOK;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  hpos_in = hpos_ff + 3'd1;
               end
            end
            PH_PAYLOAD: begin
               if (frame_active) begin
                  if (fbyte_ff == 6'd0) begin
                     fin_in = (rem_ff < pfbd_pkg::LENGTH_W'(2 * pfbd_pkg::FRAME_BYTES));
                  end
                  if (fbyte_ff < 6'(pfbd_pkg::PLANE_BYTES)) begin
                     acc_in = acc_sum;
                  end
                  if (fbyte_ff == 6'(pfbd_pkg::FRAME_BYTES - 2)) begin
                     thigh_in = req_bus.data_byte;
                  end
                  if (frame_end_now) begin
                     acc_in    = '0;
                     findex_in = findex_ff + 1'b1;
                     fbyte_in  = 6'd0;
                  end else begin
                     fbyte_in = fbyte_ff + 6'd1;
                  end
               end
               rem_in = rem_ff - 1'b1;
               if (rem_ff == pfbd_pkg::LENGTH_W'(1)) begin
                  ecount_in = ecount_ff + 1'b1;
                  phase_in  = PH_LOOK;
                  hpos_in   = 3'd0;
               end
            end
            PH_LOOK: begin
               if (hpos_ff < 3'd2) begin
                  if (hpos_ff == 3'd0) begin
                     look_in[7:0] = req_bus.data_byte;
                  end else begin
                     look_in[15:8] = req_bus.data_byte;
                  end
                  hpos_in = hpos_ff + 3'd1;
               end else if (three == cfg_footer_ff) begin
                  phase_in = PH_SKIP;
                  rem_in   = pfbd_pkg::LENGTH_W'(pfbd_pkg::FOOTER_BYTES
                                                 - pfbd_pkg::FOOTER_MATCH);
                  hpos_in  = 3'd0;
               end else begin
                  // The three bytes were really the start of the next header.
                  hmatch_in = (three == cfg_header_ff);
                  hpos_in   = 3'd3;
                  phase_in  = PH_HEADER;
               end
            end
            PH_SKIP: begin
               if (rem_ff <= pfbd_pkg::LENGTH_W'(1)) begin
                  rem_in    = '0;
                  hpos_in   = 3'd0;
                  hmatch_in = 1'b1;
                  phase_in  = PH_HEADER;
               end else begin
                  rem_in = rem_ff - 1'b1;
               end
            end
            default: phase_in = PH_HEADER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hpos_ff       <= 3'd0;
         len_ff        <= '0;
         rem_ff        <= '0;
         fbyte_ff      <= 6'd0;
         findex_ff     <= '0;
         ecount_ff     <= '0;
         acc_ff        <= '0;
         hmatch_ff     <= 1'b1;
         thigh_ff      <= 8'd0;
         look_ff       <= 16'd0;
         fin_ff        <= 1'b0;
         cfg_map_ff    <= pfbd_pkg::PIXEL_MAP_RESET;
         cfg_header_ff <= 24'd0;
         cfg_footer_ff <= 24'd0;
      end else begin
         phase_ff  <= phase_in;
         hpos_ff   <= hpos_in;
         len_ff    <= len_in;
         rem_ff    <= rem_in;
         fbyte_ff  <= fbyte_in;
         findex_ff <= findex_in;
         ecount_ff <= ecount_in;
         acc_ff    <= acc_in;
         hmatch_ff <= hmatch_in;
         thigh_ff  <= thigh_in;
         look_ff   <= look_in;
         fin_ff    <= fin_in;
         if (csr_we) begin
            case (csr_index)
               pfbd_pkg::REG_PIXEL_MAP:      cfg_map_ff    <= csr_wdata;
               pfbd_pkg::REG_HEADER_PATTERN: cfg_header_ff <= csr_wdata[23:0];
               pfbd_pkg::REG_FOOTER_PATTERN: cfg_footer_ff <= csr_wdata[23:0];
               default: ;
            endcase
         end
      end
   end

   `PFBD_ASSERT_IMP(a_acc_clear_between_frames, clock, reset, fbyte_ff == 6'd0, acc_ff == '0, "accumulators hold bits outside a frame")

endmodule

FILE: rtl/pfbd_queue.sv
`timescale 1ns / 1ps
`include "pixel_frame_bitplane_decoder_macros.svh"

// Short frame queue between parser and serializer.
module pfbd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  pfbd_pkg::queue_push_type  push,
   input  logic                      pop,
   output pfbd_pkg::frame_rec_type   head,
   output pfbd_pkg::queue_stat_type  stat
);

   pfbd_pkg::frame_rec_type               entry_ff [pfbd_pkg::QUEUE_DEPTH];
   logic [pfbd_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pfbd_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pfbd_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == pfbd_pkg::QUEUE_CNT_W'(pfbd_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.rec;
      end
   end

   `PFBD_ASSERT_IMP(a_no_overflow, clock, reset, push.valid, !stat.full, "frame pushed into a full queue")
   `PFBD_ASSERT_IMP(a_no_underflow, clock, reset, pop, !stat.empty, "frame popped from an empty queue")
   `PFBD_ASSERT_NXT(a_push_visible, clock, reset, push.valid && !pop, !stat.empty, "pushed frame lost")

endmodule

FILE: rtl/pfbd_back.sv
`timescale 1ns / 1ps

// Result serializer: the head frame yields sixteen pixel results,
// one per cycle while ready holds, via a registered output stage.
module pfbd_back (
   input  logic                      clock,
   input  logic                      reset,
   pfbd_rsp_if.source                rsp_bus,
   input  pfbd_pkg::frame_rec_type   head,
   input  pfbd_pkg::queue_stat_type  stat,
   output logic                      pop
);

   logic [pfbd_pkg::PIX_IDX_W-1:0]    idx_ff, idx_in;
   logic                              valid_ff, valid_in;
   logic [pfbd_pkg::PIX_IDX_W-1:0]    pix_idx_ff;
   logic [pfbd_pkg::PIX_W-1:0]        pix_val_ff;
   logic [pfbd_pkg::FRAME_NUM_W-1:0]  frame_num_ff;
   logic [pfbd_pkg::EVENT_NUM_W-1:0]  event_num_ff;
   logic                              trailer_ok_ff;
   logic                              header_ok_ff;
   logic                              final_ff;
   logic                              last_ff;
   logic                              load;
   logic                              idx_last;

   assign idx_last = (idx_ff == pfbd_pkg::PIX_IDX_W'(pfbd_pkg::PIXELS - 1));
   assign load     = !stat.empty && (!valid_ff || rsp_bus.ready);
   assign pop      = load && idx_last;

   always_comb begin
      idx_in   = load ? idx_ff + 1'b1 : idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         pix_idx_ff    <= idx_ff;
         pix_val_ff    <= head.pixels[idx_ff];
         frame_num_ff  <= head.frame_number;
         event_num_ff  <= head.event_number;
         trailer_ok_ff <= head.trailer_ok;
         header_ok_ff  <= head.header_ok;
         final_ff      <= head.final_frame;
         last_ff       <= idx_last;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.pixel_index  = pix_idx_ff;
   assign rsp_bus.pixel_value  = pix_val_ff;
   assign rsp_bus.frame_number = frame_num_ff;
   assign rsp_bus.event_number = event_num_ff;
   assign rsp_bus.trailer_ok   = trailer_ok_ff;
   assign rsp_bus.header_ok    = header_ok_ff;
   assign rsp_bus.final_frame  = final_ff;
   assign rsp_bus.last         = last_ff;

endmodule

FILE: rtl/pixel_frame_bitplane_decoder.sv
`timescale 1ns / 1ps

// Channel    Direction  Carries
// req_bus    in         one readout byte per request (data_byte)
// rsp_bus    out        one pixel result per transfer (index, value, frame info)
// csr_*      in         register writes: pixel map, header and footer patterns
//
// The parser takes one request per cycle unless a stall holds ready low.
// Each whole frame of 40 bytes yields 16 results, sent one per cycle by the
// serializer while rsp_bus ready is high; a finished frame passes through
// the queue and then the output register before its first result is offered.
// Reset is synchronous and active high; it clears the control registers
// but not the queue entries or result data registers; no clearing pass follows.
// Requests stall only when the two-frame queue is full and the next byte
// would close a frame; the result side stalls on its own ready alone.

// The decoder splits into three parts. The front parses the stream: it
// matches the header, assembles the little-endian payload length, folds
// each plane byte of a frame into sixteen pixel accumulators through the
// pixel map, checks the trailer and then looks ahead for a footer. A
// finished frame is pushed as one record into a short queue. The back pops
// records and serializes them into pixel results through an output register.
module pixel_frame_bitplane_decoder (
   input  logic                               clock,
   input  logic                               reset,
   pfbd_req_if.sink                           req_bus,
   pfbd_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [pfbd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                        csr_wdata
);

   pfbd_pkg::queue_push_type  push;
   pfbd_pkg::queue_stat_type  stat;
   pfbd_pkg::frame_rec_type   head;
   logic                      pop;

   // Parser with configuration registers and pixel accumulators.
   pfbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .push      (push)
   );

   // Frame records wait here so the parser keeps taking bytes while
   // results of an earlier frame are still going out.
   pfbd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (stat)
   );

   // Serializer that walks pixels 0 to 15 of the head record.
   pfbd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .rsp_bus (rsp_bus),
      .head    (head),
      .stat    (stat),
      .pop     (pop)
   );

endmodule
